>>> design/ntr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ntr_pkg;

  localparam int PIX_W       = 30;
  localparam int ORD_W       = 4;
  localparam int COORD_W     = 15;
  localparam int NSIDE_W     = 16;
  localparam int JR_W        = 18;
  localparam int JPT_W       = 17;
  localparam int FACE_W      = 4;
  localparam int COL_W       = 3;
  localparam int CPROD_W     = COL_W + NSIDE_W;
  localparam int JP_W        = 21;
  localparam int ORD_FULL    = 13;
  localparam logic [ORD_W-1:0] RESET_ORDER = 4'd10;
  localparam logic [FACE_W-1:0] LAST_FACE  = 4'd11;

  typedef enum logic [2:0] {
    REG_NORTH = 3'b001,
    REG_EQU   = 3'b010,
    REG_SOUTH = 3'b100
  } region_t;

  typedef struct packed {
    logic                err;
    logic [FACE_W-1:0]   face;
    logic [COORD_W-1:0]  ix;
    logic [COORD_W-1:0]  iy;
  } dec_t;

  typedef struct packed {
    logic                     err;
    region_t                  region;
    logic [NSIDE_W-1:0]       nr;
    logic [JR_W-1:0]          jr;
    logic signed [JPT_W-1:0]  jpt;
    logic [COL_W-1:0]         col;
    logic                     kshift;
  } ring_t;

  typedef struct packed {
    logic                     err;
    region_t                  region;
    logic [PIX_W-1:0]         poly;
    logic [PIX_W-1:0]         eqnb;
    logic [CPROD_W-1:0]       colprod;
    logic signed [JPT_W-1:0]  jpt;
    logic                     kshift;
  } prod_t;

  function automatic logic [2:0] face_row(input logic [FACE_W-1:0] face);
    case (face)
      4'd0, 4'd1, 4'd2, 4'd3:   face_row = 3'd2;
      4'd4, 4'd5, 4'd6, 4'd7:   face_row = 3'd3;
      default:                  face_row = 3'd4;
    endcase
  endfunction

  function automatic logic [COL_W-1:0] face_col(input logic [FACE_W-1:0] face);
    case (face)
      4'd0, 4'd8:   face_col = 3'd1;
      4'd1, 4'd9:   face_col = 3'd3;
      4'd2, 4'd10:  face_col = 3'd5;
      4'd3, 4'd11:  face_col = 3'd7;
      4'd4:         face_col = 3'd0;
      4'd5:         face_col = 3'd2;
      4'd6:         face_col = 3'd4;
      4'd7:         face_col = 3'd6;
      default:      face_col = 3'd7;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> design/ntr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ntr_in_if import ntr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] nested_pixel;

  modport source(output valid, output nested_pixel, input ready);
  modport sink(input valid, input nested_pixel, output ready);
endinterface

`default_nettype wire

>>> design/ntr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ntr_out_if import ntr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] ring_pixel;
  logic             range_error;

  modport source(output valid, output ring_pixel, output range_error, input ready);
  modport sink(input valid, input ring_pixel, input range_error, output ready);
endinterface

`default_nettype wire

>>> design/ntr_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module ntr_decode import ntr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [ORD_W-1:0] order,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire logic [PIX_W-1:0] up_pix,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output dec_t                  dn_data
);

  logic             valid_r;
  dec_t             data_r;
  dec_t             data_nxt;
  logic [PIX_W-1:0] zpix;
  logic [PIX_W-1:0] face_full;
  logic [4:0]       shamt;
  logic [31:0]      npix;
  logic             beyond;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    zpix      = up_pix - PIX_W'(1);
    shamt     = {order, 1'b0};
    face_full = zpix >> shamt;
    npix      = 32'd12 << shamt;
    beyond    = (int'(order) <= ORD_FULL) && ({2'b00, up_pix} > npix);
    data_nxt.err  = (up_pix == '0) || beyond;
    data_nxt.face = (face_full > PIX_W'(LAST_FACE)) ? LAST_FACE : face_full[FACE_W-1:0];
    for (int b = 0; b < COORD_W; b++) begin
      data_nxt.ix[b] = zpix[2*b]   && (b < int'(order));
      data_nxt.iy[b] = zpix[2*b+1] && (b < int'(order));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/ntr_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module ntr_ring import ntr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [ORD_W-1:0] order,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  dec_t                  up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output ring_t                 dn_data
);

  logic               valid_r;
  ring_t              data_r;
  ring_t              data_nxt;
  logic [NSIDE_W-1:0] nside;
  logic [JR_W-1:0]    top_row;
  logic [JR_W-1:0]    jrt;
  logic [JR_W-1:0]    jr;
  logic [JR_W-1:0]    nside3;
  logic [JR_W-1:0]    nl4;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    nside   = NSIDE_W'(1) << order;
    top_row = JR_W'(face_row(up_data.face)) * JR_W'(nside);
    jrt     = JR_W'(up_data.ix) + JR_W'(up_data.iy);
    jr      = top_row - jrt - JR_W'(1);
    nl4     = JR_W'({nside, 2'b00});
    nside3  = JR_W'(nside) + JR_W'({nside, 1'b0});
    data_nxt.err    = up_data.err;
    data_nxt.jr     = jr;
    data_nxt.jpt    = $signed(JPT_W'(up_data.ix)) - $signed(JPT_W'(up_data.iy));
    data_nxt.col    = face_col(up_data.face);
    data_nxt.kshift = 1'b0;
    if (jr < JR_W'(nside)) begin
      data_nxt.region = REG_NORTH;
      data_nxt.nr     = jr[NSIDE_W-1:0];
    end else if (jr > nside3) begin
      data_nxt.region = REG_SOUTH;
      data_nxt.nr     = NSIDE_W'(nl4 - jr);
    end else begin
      data_nxt.region = REG_EQU;
      data_nxt.nr     = nside;
      data_nxt.kshift = jr[0] ^ nside[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/ntr_mult.sv
`timescale 1ns / 1ps
`default_nettype none

module ntr_mult import ntr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [ORD_W-1:0] order,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  ring_t                 up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output prod_t                 dn_data
);

  logic                 valid_r;
  prod_t                data_r;
  prod_t                data_nxt;
  logic [NSIDE_W-1:0]   nside;
  logic [NSIDE_W:0]     nr_adj;
  logic [JR_W:0]        eq_term;
  logic [2*NSIDE_W:0]   poly_full;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    nside     = NSIDE_W'(1) << order;
    nr_adj    = (up_data.region == REG_NORTH) ? ({1'b0, up_data.nr} - (NSIDE_W+1)'(1))
                                              : ({1'b0, up_data.nr} + (NSIDE_W+1)'(1));
    poly_full = (2*NSIDE_W+1)'(up_data.nr) * (2*NSIDE_W+1)'(nr_adj);
    eq_term   = {up_data.jr, 1'b0} - (JR_W+1)'(nside) - (JR_W+1)'(1);
    data_nxt.err     = up_data.err;
    data_nxt.region  = up_data.region;
    data_nxt.poly    = poly_full[PIX_W-1:0];
    data_nxt.eqnb    = PIX_W'(eq_term) << ({1'b0, order} + 5'd1);
    data_nxt.colprod = CPROD_W'(up_data.col) * CPROD_W'(up_data.nr);
    data_nxt.jpt     = up_data.jpt;
    data_nxt.kshift  = up_data.kshift;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/ntr_assemble.sv
`timescale 1ns / 1ps
`default_nettype none

module ntr_assemble import ntr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [ORD_W-1:0] order,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  prod_t                 up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output logic [PIX_W-1:0]      dn_ring_pixel,
  output logic                  dn_range_error
);

  logic                    valid_r;
  logic [PIX_W-1:0]        ring_r;
  logic [PIX_W-1:0]        ring_nxt;
  logic                    err_r;
  logic [NSIDE_W-1:0]      nside;
  logic [35:0]             npix_full;
  logic [PIX_W-1:0]        nbefore;
  logic signed [JP_W-1:0]  nl4;
  logic signed [JP_W-1:0]  jp_num;
  logic signed [JP_W-1:0]  jp_half;
  logic signed [JP_W-1:0]  jp;

  assign up_ready       = !valid_r || dn_ready;
  assign dn_valid       = valid_r;
  assign dn_ring_pixel  = ring_r;
  assign dn_range_error = err_r;

  always_comb begin
    nside     = NSIDE_W'(1) << order;
    npix_full = 36'd12 << {order, 1'b0};
    case (up_data.region)
      REG_NORTH: nbefore = {up_data.poly[PIX_W-2:0], 1'b0};
      REG_SOUTH: nbefore = npix_full[PIX_W-1:0] - {up_data.poly[PIX_W-2:0], 1'b0};
      REG_EQU:   nbefore = up_data.eqnb;
      default:   nbefore = up_data.eqnb;
    endcase
    nl4     = $signed(JP_W'({nside, 2'b00}));
    jp_num  = $signed(JP_W'(up_data.colprod)) + JP_W'($signed(up_data.jpt))
              + $signed(JP_W'(1)) + $signed(JP_W'(up_data.kshift));
    jp_half = (jp_num + $signed(JP_W'(jp_num[JP_W-1]))) >>> 1;
    if (jp_half > nl4) begin
      jp = jp_half - nl4;
    end else if (jp_half < $signed(JP_W'(1))) begin
      jp = jp_half + nl4;
    end else begin
      jp = jp_half;
    end
    ring_nxt = up_data.err ? '0 : (nbefore + PIX_W'(jp));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ring_r <= ring_nxt;
      err_r  <= up_data.err;
    end
  end

endmodule

`default_nettype wire

>>> design/nested_to_ring_pixel_index.sv
// Channel   Direction  Payload                        Transfer
// in_ch     input      nested_pixel[29:0]             valid && ready
// out_ch    output     ring_pixel[29:0], range_error  valid && ready
// cfg       input      cfg_wr_data[3:0]               cfg_wr_en
//
// Four register stages: decode, ring search, multiply, assemble.
// One transfer per cycle unless out_ch stalls; each stage holds its own valid bit.
// A stalled output only holds the stages that are full, so bubbles close up.
// Reset clears the valid bits and sets the order to 10.
`timescale 1ns / 1ps
`default_nettype none

module nested_to_ring_pixel_index import ntr_pkg::*; #(
  parameter int MAX_ORDER = 13
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  ntr_in_if.sink                in_ch,
  ntr_out_if.source             out_ch,
  input  wire logic             cfg_wr_en,
  input  wire logic [ORD_W-1:0] cfg_wr_data
);

  logic [ORD_W-1:0] order_r;
  logic [ORD_W-1:0] order_act;
  logic             dec_valid;
  logic             dec_ready;
  dec_t             dec_data;
  logic             ring_valid;
  logic             ring_ready;
  ring_t            ring_data;
  logic             prod_valid;
  logic             prod_ready;
  prod_t            prod_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= RESET_ORDER;
    end else if (cfg_wr_en) begin
      order_r <= cfg_wr_data;
    end
  end

  assign order_act = (int'(order_r) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : order_r;

  ntr_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .order    (order_act),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_pix   (in_ch.nested_pixel),
    .dn_valid (dec_valid),
    .dn_ready (dec_ready),
    .dn_data  (dec_data)
  );

  ntr_ring u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .order    (order_act),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_data  (dec_data),
    .dn_valid (ring_valid),
    .dn_ready (ring_ready),
    .dn_data  (ring_data)
  );

  ntr_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .order    (order_act),
    .up_valid (ring_valid),
    .up_ready (ring_ready),
    .up_data  (ring_data),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_data  (prod_data)
  );

  ntr_assemble u_assemble (
    .clk            (clk),
    .rst_n          (rst_n),
    .order          (order_act),
    .up_valid       (prod_valid),
    .up_ready       (prod_ready),
    .up_data        (prod_data),
    .dn_valid       (out_ch.valid),
    .dn_ready       (out_ch.ready),
    .dn_ring_pixel  (out_ch.ring_pixel),
    .dn_range_error (out_ch.range_error)
  );

endmodule

`default_nettype wire
